FILE: hdl/drrip_dead_block_replacement_core_defines.svh
// Assertion macros for the checker file of this block.
`ifndef DRRIP_DEAD_BLOCK_REPLACEMENT_CORE_DEFINES_SVH
`define DRRIP_DEAD_BLOCK_REPLACEMENT_CORE_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define DRRIP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Assertion that is checked at every edge, reset included.
`define DRRIP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/drrip_pkg.sv
package drrip_pkg;

   // Default configuration of the core.
   localparam int NUM_SETS_DEF       = 2048;
   localparam int NUM_WAYS_DEF       = 16;
   localparam int NUM_LEADERS_DEF    = 64;
   localparam int SELECTOR_WIDTH_DEF = 10;

   // Fixed field widths.
   localparam int SET_IN_W = 11;
   localparam int WAY_IN_W = 4;
   localparam int MASK_W   = 16;
   localparam int RND_W    = 5;
   localparam int RV_W     = 2;

   localparam logic [RV_W-1:0] RV_MAX   = 2'd3;
   localparam logic [RV_W-1:0] RV_RESET = 2'd2;

   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [1:0] {
      KIND_SRRIP    = 2'd0,
      KIND_BRRIP    = 2'd1,
      KIND_FOLLOWER = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } fsm_state_type;

   typedef struct packed {
      logic                op;
      logic [SET_IN_W-1:0] set_index;
      logic [WAY_IN_W-1:0] way_index;
      logic                was_hit;
      logic [MASK_W-1:0]   valid_mask;
      logic [RND_W-1:0]    random_bits;
   } req_payload_type;

   typedef struct packed {
      logic [WAY_IN_W-1:0] victim_way;
      logic [RV_W-1:0]     inserted_value;
   } rsp_payload_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

FILE: hdl/drrip_if.sv
interface drrip_req_if;
   logic                        valid;
   logic                        ready;
   drrip_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface drrip_rsp_if;
   logic                        valid;
   logic                        ready;
   drrip_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/drrip_ram.sv
module drrip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/drrip_ctrl.sv
module drrip_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output drrip_pkg::ctrl_cmd_type  cmd,
   input  drrip_pkg::dp_status_type status
);

   drrip_pkg::fsm_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The output register can take a result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drrip_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         drrip_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = drrip_pkg::ST_IDLE;
            end
         end
         drrip_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = drrip_pkg::ST_LOOKUP;
            end
         end
         drrip_pkg::ST_LOOKUP: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = drrip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drrip_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/drrip_datapath.sv
module drrip_datapath #(
   parameter int NUM_SETS       = drrip_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS       = drrip_pkg::NUM_WAYS_DEF,
   parameter int NUM_LEADERS    = drrip_pkg::NUM_LEADERS_DEF,
   parameter int SELECTOR_WIDTH = drrip_pkg::SELECTOR_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  drrip_pkg::ctrl_cmd_type     cmd,
   output drrip_pkg::dp_status_type    status,
   input  drrip_pkg::req_payload_type  req_payload,
   output drrip_pkg::rsp_payload_type  rsp_payload
);

   localparam int SetAw  = $clog2(NUM_SETS);
   localparam int WayAw  = $clog2(NUM_WAYS);
   localparam int RvW    = drrip_pkg::RV_W;
   localparam int DcLo   = RvW * NUM_WAYS;
   localparam int KindLo = 2 * RvW * NUM_WAYS;
   localparam int RowW   = KindLo + 2;
   // Quotient bits needed to fold an incoming set number into range.
   localparam int QuoB   = $clog2(((2 ** drrip_pkg::SET_IN_W) - 1) / NUM_SETS + 1);
   localparam int RedW   = (SetAw + QuoB + 1 > drrip_pkg::SET_IN_W + 1) ?
                           SetAw + QuoB + 1 : drrip_pkg::SET_IN_W + 1;
   localparam int QuoW   = $clog2(NUM_LEADERS + 1);
   localparam int KindW  = $clog2(NUM_SETS + NUM_LEADERS + 1) + 1;
   localparam int LDivN  = NUM_LEADERS / NUM_SETS;
   localparam int LModN  = NUM_LEADERS % NUM_SETS;
   localparam logic [SELECTOR_WIDTH-1:0] SelMax = '1;
   localparam logic [SELECTOR_WIDTH-1:0] SelMid = {1'b1, {(SELECTOR_WIDTH-1){1'b0}}};

   function automatic logic [SetAw-1:0] reduce_set(input logic [drrip_pkg::SET_IN_W-1:0] raw);
      logic [RedW-1:0] v;
      logic [RedW-1:0] step;
      v = RedW'(raw);
      for (int k = QuoB - 1; k >= 0; k--) begin
         step = RedW'(NUM_SETS) << k;
         if (v >= step) begin
            v = v - step;
         end
      end
      return SetAw'(v);
   endfunction

   // Clearing pass state: set counter plus a running s*L mod N and quotient.
   logic [SetAw-1:0]  clr_set_ff, clr_set_in;
   logic [SetAw-1:0]  clr_acc_ff, clr_acc_in;
   logic [QuoW-1:0]   clr_quo_ff, clr_quo_in;
   logic [SetAw:0]    clr_acc_sum;
   logic              clr_wrap;
   logic              clr_rnz;
   logic              clr_leader;
   logic [QuoW-1:0]   clr_lidx;
   drrip_pkg::kind_type clr_kind;
   logic [RowW-1:0]   clr_row;

   // Item held during the lookup.
   logic                          op_ff;
   logic [SetAw-1:0]              set_ff;
   logic [drrip_pkg::WAY_IN_W-1:0] way_ff;
   logic                          hit_ff;
   logic [drrip_pkg::MASK_W-1:0]  mask_ff;
   logic [drrip_pkg::RND_W-1:0]   rnd_ff;

   logic [SELECTOR_WIDTH-1:0] sel_ff, sel_in;
   drrip_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [SetAw-1:0] req_set;
   logic [RowW-1:0]  rd_row;
   logic [RowW-1:0]  new_row;
   logic             ram_we;
   logic [SetAw-1:0] ram_waddr;
   logic [RowW-1:0]  ram_wdata;

   logic [RvW-1:0]   rv_old [NUM_WAYS];
   logic [RvW-1:0]   dc_old [NUM_WAYS];
   logic [RvW-1:0]   aged   [NUM_WAYS];
   logic             has3, has2, has1;
   logic [RvW-1:0]   top;
   logic [RvW-1:0]   age_add;
   logic             inv_found;
   logic [WayAw-1:0] inv_way;
   logic             age_found;
   logic [WayAw-1:0] age_way;
   logic [WayAw-1:0] victim;

   logic             in_range;
   logic [WayAw-1:0] wsel;
   logic [RvW-1:0]   dc_sel;
   logic [RvW-1:0]   dc_new;
   drrip_pkg::kind_type kind;
   logic             brrip_sel;
   logic [RvW-1:0]   ins_val;

   // ---------------- clearing pass ----------------
   assign clr_acc_sum = (SetAw + 1)'(clr_acc_ff) + (SetAw + 1)'(LModN);
   assign clr_wrap    = clr_acc_sum >= (SetAw + 1)'(NUM_SETS);
   assign clr_rnz     = clr_acc_ff != '0;
   assign clr_leader  = !clr_rnz ||
                        (KindW'(clr_acc_ff) + KindW'(NUM_LEADERS) > KindW'(NUM_SETS));
   assign clr_lidx    = clr_quo_ff + QuoW'(clr_rnz);
   assign clr_kind    = !clr_leader ? drrip_pkg::KIND_FOLLOWER :
                        (clr_lidx < QuoW'(NUM_LEADERS / 2)) ? drrip_pkg::KIND_SRRIP :
                                                               drrip_pkg::KIND_BRRIP;
   assign clr_row     = {clr_kind, {DcLo{1'b0}}, {NUM_WAYS{drrip_pkg::RV_RESET}}};

   always_comb begin
      clr_set_in = clr_set_ff;
      clr_acc_in = clr_acc_ff;
      clr_quo_in = clr_quo_ff;
      if (cmd.clear_wr) begin
         clr_set_in = clr_set_ff + SetAw'(1);
         clr_acc_in = clr_wrap ? SetAw'(clr_acc_sum - (SetAw + 1)'(NUM_SETS)) :
                                 SetAw'(clr_acc_sum);
         clr_quo_in = clr_quo_ff + QuoW'(LDivN) + QuoW'(clr_wrap);
      end
   end

   assign status.clear_last = clr_set_ff == SetAw'(NUM_SETS - 1);

   // ---------------- row memory ----------------
   assign req_set   = reduce_set(req_payload.set_index);
   assign ram_we    = cmd.clear_wr || cmd.commit;
   assign ram_waddr = cmd.clear_wr ? clr_set_ff : set_ff;
   assign ram_wdata = cmd.clear_wr ? clr_row : new_row;

   drrip_ram #(
      .WIDTH (RowW),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (req_set),
      .rd_data (rd_row)
   );

   // ---------------- victim search ----------------
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         rv_old[w] = rd_row[RvW*w +: RvW];
         dc_old[w] = rd_row[DcLo + RvW*w +: RvW];
      end
      has3 = 1'b0;
      has2 = 1'b0;
      has1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         has3 = has3 | (rv_old[w] == 2'd3);
         has2 = has2 | (rv_old[w] == 2'd2);
         has1 = has1 | (rv_old[w] == 2'd1);
      end
      top     = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;
      age_add = drrip_pkg::RV_MAX - top;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged[w] = rv_old[w] + age_add;
      end
      inv_found = 1'b0;
      inv_way   = '0;
      age_found = 1'b0;
      age_way   = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (w < drrip_pkg::MASK_W && !inv_found) begin
            if (!mask_ff[4'(w)]) begin
               inv_found = 1'b1;
               inv_way   = WayAw'(w);
            end
         end
         if (aged[w] == drrip_pkg::RV_MAX && !age_found) begin
            age_found = 1'b1;
            age_way   = WayAw'(w);
         end
      end
      victim = inv_found ? inv_way : age_way;
   end

   // ---------------- update ----------------
   always_comb begin
      in_range = int'(way_ff) < NUM_WAYS;
      wsel     = WayAw'(way_ff);
      dc_sel   = dc_old[wsel];
      if (hit_ff) begin
         dc_new = '0;
      end else if (dc_sel == drrip_pkg::RV_MAX) begin
         dc_new = drrip_pkg::RV_MAX;
      end else begin
         dc_new = dc_sel + 2'd1;
      end
      kind = drrip_pkg::kind_type'(rd_row[KindLo +: 2]);
      case (kind)
         drrip_pkg::KIND_SRRIP: brrip_sel = 1'b0;
         drrip_pkg::KIND_BRRIP: brrip_sel = 1'b1;
         default:               brrip_sel = sel_ff < SelMid;
      endcase
      if (dc_new == drrip_pkg::RV_MAX) begin
         ins_val = drrip_pkg::RV_MAX;
      end else if (brrip_sel && rnd_ff == '0) begin
         ins_val = drrip_pkg::RV_MAX;
      end else begin
         ins_val = drrip_pkg::RV_RESET;
      end
   end

   always_comb begin
      new_row = rd_row;
      if (op_ff == drrip_pkg::OP_VICTIM) begin
         if (!inv_found) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               new_row[RvW*w +: RvW] = aged[w];
            end
         end
      end else if (in_range) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (WayAw'(w) == wsel) begin
               new_row[RvW*w +: RvW]        = ins_val;
               new_row[DcLo + RvW*w +: RvW] = dc_new;
            end
         end
      end
   end

   always_comb begin
      sel_in = sel_ff;
      if (cmd.commit && op_ff == drrip_pkg::OP_UPDATE && in_range && !hit_ff) begin
         case (kind)
            drrip_pkg::KIND_SRRIP: begin
               if (sel_ff != SelMax) begin
                  sel_in = sel_ff + SELECTOR_WIDTH'(1);
               end
            end
            drrip_pkg::KIND_BRRIP: begin
               if (sel_ff != '0) begin
                  sel_in = sel_ff - SELECTOR_WIDTH'(1);
               end
            end
            default: begin
               sel_in = sel_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.commit) begin
         if (op_ff == drrip_pkg::OP_VICTIM) begin
            rsp_in.victim_way     = drrip_pkg::WAY_IN_W'(victim);
            rsp_in.inserted_value = '0;
         end else begin
            rsp_in.victim_way     = '0;
            rsp_in.inserted_value = in_range ? ins_val : '0;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_set_ff <= '0;
         clr_acc_ff <= '0;
         clr_quo_ff <= '0;
         sel_ff     <= SelMid;
      end else begin
         clr_set_ff <= clr_set_in;
         clr_acc_ff <= clr_acc_in;
         clr_quo_ff <= clr_quo_in;
         sel_ff     <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.accept) begin
         op_ff   <= req_payload.op;
         set_ff  <= req_set;
         way_ff  <= req_payload.way_index;
         hit_ff  <= req_payload.was_hit;
         mask_ff <= req_payload.valid_mask;
         rnd_ff  <= req_payload.random_bits;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/drrip_dead_block_replacement_core.sv
// A request transfer starts the row read; in the lookup state the result is
// registered once the response side is free, and a stalled response holds
// the following request in its lookup. Requests are taken one at a time,
// each with a read-modify-write of one set row whose write-back lands
// before the next row read. Reset: synchronous; afterwards a clearing pass
// writes every set row (NUM_SETS, 2048 by default) with req_if.ready held low.
module drrip_dead_block_replacement_core #(
   parameter int NUM_SETS       = drrip_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS       = drrip_pkg::NUM_WAYS_DEF,
   parameter int NUM_LEADERS    = drrip_pkg::NUM_LEADERS_DEF,
   parameter int SELECTOR_WIDTH = drrip_pkg::SELECTOR_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   drrip_req_if.sink   req_if,
   drrip_rsp_if.source rsp_if
);

   // The core is split into a small sequencer and a datapath. The sequencer
   // walks the clearing pass after reset, takes one request at a time, and
   // commits the result into the response register once that register is
   // free. Each row of the set memory holds the re-reference values and dead
   // counters of every way of one set, plus a two-bit set kind (SRRIP leader,
   // BRRIP leader or follower). The kind is computed once per set during the
   // clearing pass, so no leader search is needed on the request path.

   drrip_pkg::ctrl_cmd_type  cmd;
   drrip_pkg::dp_status_type status;

   drrip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // On a transfer the datapath starts the row read and captures the request.
   // In the following cycle the row data is back; the victim search (first
   // invalid way, else aging to the smallest shift that reaches the maximum
   // value) or the update (dead counter, dueling selector, insertion value)
   // is evaluated; once the response register is free, the row is written back and the response is registered.
   // Since the write lands before the next request can read, back-to-back
   // requests to the same set always see the updated row.
   drrip_datapath #(
      .NUM_SETS       (NUM_SETS),
      .NUM_WAYS       (NUM_WAYS),
      .NUM_LEADERS    (NUM_LEADERS),
      .SELECTOR_WIDTH (SELECTOR_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_if.payload),
      .rsp_payload (rsp_if.payload)
   );

endmodule

FILE: hdl/drrip_checker.sv
`include "drrip_dead_block_replacement_core_defines.svh"

module drrip_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input drrip_pkg::rsp_payload_type rsp_payload
);

   `DRRIP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "response dropped or changed while stalled")
   `DRRIP_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready, "request taken during the clearing pass")
   `DRRIP_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while another is in the lookup")
   `DRRIP_ASSERT(a_unused_zero, clock, reset, rsp_valid |-> (rsp_payload.victim_way == '0 || rsp_payload.inserted_value == '0), "both response fields nonzero")

endmodule

bind drrip_dead_block_replacement_core drrip_checker u_drrip_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

FILE: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import drrip_pkg::*;

   // The core is checked at its default configuration.
   localparam int SETS    = NUM_SETS_DEF;
   localparam int WAYS    = NUM_WAYS_DEF;
   localparam int LEADERS = NUM_LEADERS_DEF;
   localparam int SEL_W   = SELECTOR_WIDTH_DEF;

   localparam logic [SEL_W-1:0] PSEL_TOP = '1;
   localparam logic [SEL_W-1:0] PSEL_MID = SEL_W'(1 << (SEL_W - 1));

   // The random part stops once this many requests have been queued in total.
   localparam int ITEM_TARGET = 1575;
   // The run is cut off here: the clearing pass plus every request taking
   // many times its nominal time with the worst random stalls.
   localparam int CYCLE_LIMIT = 200000;
   // Cycles the response side is watched after the last expected response.
   localparam int DRAIN_CYCLES = 16;
   // Neither side idles inside this window of cycles.
   localparam int QUIET_FROM = 3500;
   localparam int QUIET_TO   = 5000;

   // One queued request. When follow_victim is set, the way of this update is
   // replaced at send time by the victim that the previous victim lookup chose,
   // so that a fill goes to the way the engine actually picked.
   typedef struct {
      req_payload_type pl;
      bit              follow_victim;
   } req_item_type;

   logic clock;
   logic reset;

   drrip_req_if req_ch ();
   drrip_rsp_if rsp_ch ();

   drrip_dead_block_replacement_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Requests waiting to be driven, and responses that the shadow engine
   // says must come back, oldest first.
   req_item_type    req_queue[$];
   rsp_payload_type expected_rsp[$];

   // Shadow copy of the replacement state.
   logic [RV_W-1:0]  rrpv_mem [SETS][WAYS];
   logic [1:0]       dead_mem [SETS][WAYS];
   logic [SEL_W-1:0] duel_psel;

   logic [WAY_IN_W-1:0] last_victim;
   int                  mismatch_count;
   int                  cycle_count;
   logic                quiet_window;

   // Bookkeeping of the stimulus generator. It follows the selector on its own
   // so that the random part knows when the selector has been driven to zero.
   int plan_psel;
   int queued_total;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Set kind per the leader layout: leader i sits at set i*SETS/LEADERS; the
   // lower half of the leaders insert SRRIP style, the upper half BRRIP style.
   function automatic kind_type leader_kind(input int unsigned s);
      for (int i = 0; i < LEADERS; i++) begin
         if ((i * SETS) / LEADERS == s) begin
            return (i < LEADERS / 2) ? KIND_SRRIP : KIND_BRRIP;
         end
      end
      return KIND_FOLLOWER;
   endfunction

   // Shadow engine: applies one request to the shadow state and returns the
   // response that the core must give for it.
   function automatic rsp_payload_type rrip_predict(input req_payload_type r);
      rsp_payload_type res;
      int unsigned     s;
      int unsigned     w;
      int unsigned     top;
      kind_type        kind;
      logic [RV_W-1:0] val;
      bit              found;
      bit              brrip_pick;
      res = '0;
      s = r.set_index % SETS;
      if (r.op == OP_VICTIM) begin
         // An invalid way wins outright; ways beyond the mask count as valid.
         found = 1'b0;
         w = 0;
         for (int i = 0; i < WAYS; i++) begin
            if (!found && i < MASK_W && !r.valid_mask[i]) begin
               found = 1'b1;
               w = i;
            end
         end
         if (!found) begin
            // Age the whole set just far enough that some way reaches the
            // distant value, then take the lowest such way.
            top = 0;
            for (int i = 0; i < WAYS; i++) begin
               if (rrpv_mem[s][i] > top) top = 32'(rrpv_mem[s][i]);
            end
            if (top < RV_MAX) begin
               for (int i = 0; i < WAYS; i++) begin
                  rrpv_mem[s][i] = rrpv_mem[s][i] + RV_W'(RV_MAX - top);
               end
            end
            for (int i = 0; i < WAYS; i++) begin
               if (!found && rrpv_mem[s][i] == RV_MAX) begin
                  found = 1'b1;
                  w = i;
               end
            end
         end
         res.victim_way = WAY_IN_W'(w);
      end else if (r.way_index < WAYS) begin
         w = 32'(r.way_index);
         kind = leader_kind(s);
         // The dead counter restarts on a hit and saturates on misses.
         if (r.was_hit) begin
            dead_mem[s][w] = '0;
         end else if (dead_mem[s][w] < RV_MAX) begin
            dead_mem[s][w] = dead_mem[s][w] + 2'd1;
         end
         // Only misses in leader sets move the dueling selector.
         if (!r.was_hit) begin
            if (kind == KIND_SRRIP && duel_psel != PSEL_TOP) begin
               duel_psel = duel_psel + 1'b1;
            end else if (kind == KIND_BRRIP && duel_psel != '0) begin
               duel_psel = duel_psel - 1'b1;
            end
         end
         if (dead_mem[s][w] == RV_MAX) begin
            val = RV_MAX;
         end else begin
            brrip_pick = (kind == KIND_BRRIP) ||
                         (kind == KIND_FOLLOWER && duel_psel < PSEL_MID);
            val = (brrip_pick && r.random_bits == '0) ? RV_MAX : RV_RESET;
         end
         rrpv_mem[s][w] = val;
         res.inserted_value = val;
      end
      return res;
   endfunction

   // Queues one request and tracks the selector movement it will cause.
   task automatic add_item(input req_payload_type pl, input bit follow);
      req_item_type it;
      kind_type     kind;
      it.pl = pl;
      it.follow_victim = follow;
      req_queue.insert(req_queue.size(), it);
      queued_total++;
      if (pl.op == OP_UPDATE && !pl.was_hit && pl.way_index < WAYS) begin
         kind = leader_kind(pl.set_index % SETS);
         if (kind == KIND_SRRIP && plan_psel < int'(PSEL_TOP)) plan_psel++;
         if (kind == KIND_BRRIP && plan_psel > 0) plan_psel--;
      end
   endtask

   task automatic add_victim(input int s, input logic [MASK_W-1:0] mask);
      req_payload_type pl;
      pl = '0;
      pl.op = OP_VICTIM;
      pl.set_index = SET_IN_W'(s);
      pl.valid_mask = mask;
      // These fields are ignored by a lookup, so they carry noise.
      pl.way_index = WAY_IN_W'($urandom);
      pl.was_hit = 1'($urandom);
      pl.random_bits = RND_W'($urandom);
      add_item(pl, 1'b0);
   endtask

   task automatic add_update(input int s, input int w, input bit hit, input int rnd,
                             input bit follow);
      req_payload_type pl;
      pl.op = OP_UPDATE;
      pl.set_index = SET_IN_W'(s);
      pl.way_index = WAY_IN_W'(w);
      pl.was_hit = hit;
      pl.random_bits = RND_W'(rnd);
      pl.valid_mask = MASK_W'($urandom);
      add_item(pl, follow);
   endtask

   // A leader set of the requested kind, mostly one of a few hot ones so that
   // their rows build up history.
   function automatic int pick_leader(input bit brrip_side);
      int base;
      base = brrip_side ? LEADERS / 2 : 0;
      case ($urandom_range(0, 3))
         0: begin
            return (base * SETS) / LEADERS;
         end
         1: begin
            return ((base + LEADERS / 2 - 1) * SETS) / LEADERS;
         end
         default: begin
            return ((base + $urandom_range(0, LEADERS / 2 - 1)) * SETS) / LEADERS;
         end
      endcase
   endfunction

   // Set choice for the random part: a pool of hot followers, leaders of both
   // kinds with a lean toward the current drive direction, and a tail of
   // arbitrary sets.
   function automatic int pick_set(input bit drive_down);
      int hot_followers [6];
      int r;
      hot_followers = '{1, 31, 500, 1023, 1025, SETS - 1};
      r = $urandom_range(0, 99);
      if (r < 30) return pick_leader(drive_down);
      if (r < 40) return pick_leader(!drive_down);
      if (r < 85) return hot_followers[$urandom_range(0, 5)];
      return $urandom_range(0, SETS - 1);
   endfunction

   // Ways are often drawn from a small group so that dead counters saturate.
   function automatic int pick_way();
      if ($urandom_range(0, 99) < 60) return $urandom_range(0, 3);
      return $urandom_range(0, WAYS - 1);
   endfunction

   function automatic int pick_rnd();
      if ($urandom_range(0, 99) < 30) return 0;
      return $urandom_range(0, 31);
   endfunction

   // Stimulus, reset and the end of the run.
   initial begin
      int              r;
      int              s;
      int              burst;
      int              zero_hold;
      bit              drive_down;
      req_payload_type pl;

      // Every input is known from time zero.
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;

      for (int i = 0; i < SETS; i++) begin
         for (int j = 0; j < WAYS; j++) begin
            rrpv_mem[i][j] = RV_RESET;
            dead_mem[i][j] = '0;
         end
      end
      duel_psel = PSEL_MID;
      last_victim = '0;
      plan_psel = int'(PSEL_MID);
      queued_total = 0;

      // Directed part. A lookup with an invalid way takes the lowest one,
      // including the top way and a mask with every bit clear.
      add_victim(5, 16'h0000);
      add_victim(5, 16'h7FFF);
      add_victim(5, 16'h0001);
      // A full set straight out of reset ages every way from the reset value
      // to the distant value; the second lookup needs no aging.
      add_victim(5, 16'hFFFF);
      add_victim(5, 16'hFFFF);
      // A follower hit with zero random bits while the selector sits at its
      // midpoint inserts SRRIP style.
      add_update(5, 0, 1'b1, 0, 1'b0);
      // Three misses on one way make it dead, so it is inserted distant; a
      // hit then revives it.
      add_update(7, 15, 1'b0, 31, 1'b0);
      add_update(7, 15, 1'b0, 31, 1'b0);
      add_update(7, 15, 1'b0, 0, 1'b0);
      add_update(7, 15, 1'b1, 0, 1'b0);
      // A miss in the first SRRIP leader, misses in BRRIP leaders with the random
      // bits zero and nonzero, and a hit in the last SRRIP leader.
      add_update(0, 3, 1'b0, 0, 1'b0);
      add_update(SETS / 2, 4, 1'b0, 0, 1'b0);
      add_update(((LEADERS - 1) * SETS) / LEADERS, 1, 1'b0, 5, 1'b0);
      add_update(((LEADERS / 2 - 1) * SETS) / LEADERS, 0, 1'b1, 0, 1'b0);
      // The selector is now below the midpoint, so the top follower set
      // inserts BRRIP style, and a full lookup there finds the distant way.
      add_update(SETS - 1, 2, 1'b0, 0, 1'b0);
      add_victim(SETS - 1, 16'hFFFF);
      add_update(SETS - 1, 9, 1'b0, 1, 1'b0);
      // An invalid way beats any re-reference value; a hit in a BRRIP leader
      // with zero random bits inserts distant.
      add_victim(SETS / 2, 16'hFFEF);
      add_update(SETS / 2, 4, 1'b1, 0, 1'b0);
      add_victim(SETS / 2, 16'hFFFF);
      add_update(SETS / 2, 0, 1'b0, 16, 1'b1);

      // Random part. First the misses lean on BRRIP leaders until the
      // selector has sat at zero for a while, then they lean on SRRIP
      // leaders so that it climbs back.
      drive_down = 1'b1;
      zero_hold = 0;
      while (queued_total < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         s = pick_set(drive_down);
         if (r < 40) begin
            // A run of misses in leaders of the current direction.
            burst = $urandom_range(1, 6);
            s = pick_leader(drive_down);
            for (int i = 0; i < burst; i++) begin
               add_update(s, pick_way(), 1'b0, pick_rnd(), 1'b0);
            end
         end else if (r < 70) begin
            // A fill: lookup, then a miss update on the chosen way.
            if ($urandom_range(0, 99) < 85) add_victim(s, 16'hFFFF);
            else add_victim(s, MASK_W'($urandom));
            add_update(s, 0, 1'b0, pick_rnd(), 1'b1);
         end else if (r < 85) begin
            add_update(s, pick_way(), 1'b1, pick_rnd(), 1'b0);
         end else begin
            // Unshaped requests over the whole field ranges.
            pl.op = 1'($urandom);
            pl.set_index = SET_IN_W'($urandom);
            pl.way_index = WAY_IN_W'($urandom);
            pl.was_hit = 1'($urandom);
            pl.valid_mask = MASK_W'($urandom);
            pl.random_bits = RND_W'($urandom);
            add_item(pl, 1'b0);
         end
         if (drive_down && plan_psel == 0) zero_hold++;
         if (zero_hold >= 40) drive_down = 1'b0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request has gone out and every response is back,
      // then keep watching the response side for anything unexpected. The
      // check sits on the falling edge, where the driver's updates have settled.
      while (req_queue.size() != 0 || req_ch.valid || expected_rsp.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Cycle count, the no-idle window and the overall time limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      quiet_window <= (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      cycle_count = 0;
      quiet_window = 1'b0;
      mismatch_count = 0;
   end

   // Request driver. On each transfer the shadow engine works out the
   // response; then the next request is offered, or the source idles. A
   // request once offered is held until its transfer.
   always @(posedge clock) begin : drive_requests
      req_item_type    nxt;
      rsp_payload_type pred;
      bit              free;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         free = !req_ch.valid || req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            pred = rrip_predict(req_ch.payload);
            expected_rsp.insert(expected_rsp.size(), pred);
            if (req_ch.payload.op == OP_VICTIM) last_victim = pred.victim_way;
         end
         if (free) begin
            if (req_queue.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 19)) begin
               nxt = req_queue.pop_front();
               // A fill targets the way that the preceding lookup returned.
               if (nxt.follow_victim) nxt.pl.way_index = last_victim;
               req_ch.valid <= 1'b1;
               req_ch.payload <= nxt.pl;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each response transfer is checked field by field
   // against the oldest expectation; ready is dropped at random to stall the
   // core.
   always @(posedge clock) begin : check_responses
      rsp_payload_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with none expected, actual victim_way %0d"
                        , $time, rsp_ch.payload.victim_way,
                        " inserted_value %0d", rsp_ch.payload.inserted_value);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_ch.payload.victim_way !== want.victim_way) begin
                  $display("%0t: victim_way expected %0d actual %0d", $time,
                           want.victim_way, rsp_ch.payload.victim_way);
                  mismatch_count++;
               end
               if (rsp_ch.payload.inserted_value !== want.inserted_value) begin
                  $display("%0t: inserted_value expected %0d actual %0d", $time,
                           want.inserted_value, rsp_ch.payload.inserted_value);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= quiet_window || ($urandom_range(0, 99) >= 19);
      end
   end

endmodule
